[sv/obs_pkg.sv]
// Shared types and constants for the oblivious bucket store.
// Used by obs_ctrl, obs_dp and oblivious_bucket_store_core; depends on nothing.
`default_nettype none

package obs_pkg;

  localparam int SLOTS_DEF        = 8;
  localparam int PAYLOAD_BITS_DEF = 64;

  localparam int KIND_W   = 2;
  localparam int IDX_W    = 32;
  localparam int LEAF_W   = 32;
  localparam int PAY_W    = 64;
  localparam int SIZE_W   = 12;
  localparam int CNT_W    = 4;
  localparam int CAP_W    = 4;
  localparam int APB_DW   = 32;
  localparam int APB_AW   = 3;

  localparam logic [CAP_W-1:0]  CAP_RESET        = 4'd4;
  localparam logic              CFG_IDX_CAPACITY = 1'b0;
  localparam logic [IDX_W-1:0]  DUMMY_ID         = 32'hFFFF_FFFF;

  typedef enum logic [KIND_W-1:0] {
    KIND_LOOKUP = 2'd0,
    KIND_ADD    = 2'd1,
    KIND_REMOVE = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FIND,
    ST_SHIFT,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic             load;
    logic             add;
    logic             rd_en;
    logic [CNT_W-1:0] rd_ptr;
    logic             cmp_en;
    logic             first_only;
    logic             shift_wr;
    logic             cnt_dec;
  } cmd_t;

  typedef struct packed {
    logic [CNT_W-1:0] cnt;
    logic             hit;
    logic [CNT_W-1:0] hit_ptr;
  } sts_t;

endpackage

`default_nettype wire

[sv/obs_dp.sv]
// Datapath of the oblivious bucket store: slot memory, block count and result registers.
// Driven by commands from obs_ctrl; depends on obs_pkg.
`default_nettype none

module obs_dp #(
  parameter int SLOTS        = obs_pkg::SLOTS_DEF,
  parameter int PAYLOAD_BITS = obs_pkg::PAYLOAD_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  obs_pkg::cmd_t                     cmd_i,
  output obs_pkg::sts_t                     sts_o,
  input  logic signed [obs_pkg::IDX_W-1:0]  in_block_index,
  input  logic signed [obs_pkg::LEAF_W-1:0] in_leaf_id,
  input  logic [obs_pkg::PAY_W-1:0]         in_payload,
  input  logic [obs_pkg::SIZE_W-1:0]        in_payload_size,
  output logic                              out_success,
  output logic signed [obs_pkg::IDX_W-1:0]  out_found_index,
  output logic signed [obs_pkg::LEAF_W-1:0] out_found_leaf,
  output logic [obs_pkg::PAY_W-1:0]         out_found_payload,
  output logic [obs_pkg::SIZE_W-1:0]        out_found_size,
  output logic [obs_pkg::CNT_W-1:0]         out_occupancy
);

  localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int EW = obs_pkg::IDX_W + obs_pkg::LEAF_W + PAYLOAD_BITS + obs_pkg::SIZE_W;

  logic [EW-1:0]                 slot_mem [SLOTS];
  logic [EW-1:0]                 rd_data_r;
  logic                          rd_vld_r;
  logic [obs_pkg::CNT_W-1:0]     rd_ptr_r;
  logic [obs_pkg::CNT_W-1:0]     count_r;
  logic [obs_pkg::CNT_W-1:0]     hit_ptr_r;
  logic [obs_pkg::IDX_W-1:0]     req_index_r;
  logic                          res_ok_r;
  logic [obs_pkg::IDX_W-1:0]     res_index_r;
  logic [obs_pkg::LEAF_W-1:0]    res_leaf_r;
  logic [PAYLOAD_BITS-1:0]       res_pay_r;
  logic [obs_pkg::SIZE_W-1:0]    res_size_r;

  logic                          wr_en;
  logic [AW-1:0]                 wr_addr;
  logic [EW-1:0]                 wr_data;
  logic [obs_pkg::IDX_W-1:0]     rd_idx;
  logic [obs_pkg::LEAF_W-1:0]    rd_leaf;
  logic [PAYLOAD_BITS-1:0]       rd_pay;
  logic [obs_pkg::SIZE_W-1:0]    rd_size;
  logic                          match;

  assign rd_idx  = rd_data_r[EW-1 -: obs_pkg::IDX_W];
  assign rd_leaf = rd_data_r[EW-obs_pkg::IDX_W-1 -: obs_pkg::LEAF_W];
  assign rd_pay  = rd_data_r[obs_pkg::SIZE_W +: PAYLOAD_BITS];
  assign rd_size = rd_data_r[obs_pkg::SIZE_W-1:0];
  assign match   = (rd_idx == req_index_r);

  always_comb begin
    wr_en   = cmd_i.add | (cmd_i.shift_wr & rd_vld_r);
    wr_addr = AW'(rd_ptr_r - obs_pkg::CNT_W'(1));
    wr_data = rd_data_r;
    if (cmd_i.add) begin
      wr_addr = AW'(count_r);
      wr_data = {in_block_index, in_leaf_id, in_payload[PAYLOAD_BITS-1:0], in_payload_size};
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slot_mem[wr_addr] <= wr_data;
    end
    if (cmd_i.rd_en) begin
      rd_data_r <= slot_mem[AW'(cmd_i.rd_ptr)];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= cmd_i.rd_en;
      if (cmd_i.add) begin
        count_r <= count_r + obs_pkg::CNT_W'(1);
      end else if (cmd_i.cnt_dec) begin
        count_r <= count_r - obs_pkg::CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_ptr_r <= cmd_i.rd_ptr;
    if (cmd_i.load) begin
      req_index_r <= in_block_index;
      res_ok_r    <= cmd_i.add;
      res_index_r <= obs_pkg::DUMMY_ID;
      res_leaf_r  <= obs_pkg::DUMMY_ID;
      res_pay_r   <= '0;
      res_size_r  <= '0;
    end else if (cmd_i.cmp_en && rd_vld_r && match) begin
      if (cmd_i.first_only) begin
        if (!res_ok_r) begin
          res_ok_r  <= 1'b1;
          hit_ptr_r <= rd_ptr_r;
        end
      end else begin
        res_ok_r    <= 1'b1;
        res_index_r <= rd_idx;
        res_leaf_r  <= rd_leaf;
        res_pay_r   <= rd_pay;
        res_size_r  <= rd_size;
      end
    end
  end

  assign sts_o.cnt     = count_r;
  assign sts_o.hit     = res_ok_r;
  assign sts_o.hit_ptr = hit_ptr_r;

  assign out_success       = res_ok_r;
  assign out_found_index   = res_index_r;
  assign out_found_leaf    = res_leaf_r;
  assign out_found_payload = obs_pkg::PAY_W'(res_pay_r);
  assign out_found_size    = res_size_r;
  assign out_occupancy     = count_r;

endmodule

`default_nettype wire

[sv/obs_ctrl.sv]
// Controller of the oblivious bucket store: sequences scans, adds and shifts.
// Issues commands to obs_dp and reads its status; depends on obs_pkg.
`default_nettype none

module obs_ctrl #(
  parameter int SLOTS = obs_pkg::SLOTS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [obs_pkg::KIND_W-1:0]  in_kind,
  input  logic [obs_pkg::CAP_W-1:0]   cap_i,
  input  obs_pkg::sts_t               sts_i,
  output obs_pkg::cmd_t               cmd_o,
  output logic                        busy,
  output logic                        out_valid
);

  obs_pkg::state_t              state_r, state_nxt;
  obs_pkg::kind_t               kind_r, kind_nxt;
  logic [obs_pkg::CNT_W-1:0]    ptr_r, ptr_nxt;
  logic [obs_pkg::CNT_W-1:0]    lim;
  logic                         more;

  always_comb begin
    if (32'(cap_i) > 32'(SLOTS)) begin
      lim = obs_pkg::CNT_W'(SLOTS);
    end else begin
      lim = cap_i;
    end
  end

  assign more = (ptr_r < sts_i.cnt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= obs_pkg::ST_IDLE;
      kind_r  <= obs_pkg::KIND_LOOKUP;
      ptr_r   <= '0;
    end else begin
      state_r <= state_nxt;
      kind_r  <= kind_nxt;
      ptr_r   <= ptr_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    kind_nxt  = kind_r;
    ptr_nxt   = ptr_r;
    case (state_r)
      obs_pkg::ST_IDLE: begin
        if (start) begin
          kind_nxt = obs_pkg::kind_t'(in_kind);
          ptr_nxt  = '0;
          if ((in_kind == obs_pkg::KIND_LOOKUP || in_kind == obs_pkg::KIND_REMOVE)
              && sts_i.cnt != '0) begin
            state_nxt = obs_pkg::ST_SCAN;
          end else begin
            state_nxt = obs_pkg::ST_DONE;
          end
        end
      end
      obs_pkg::ST_SCAN: begin
        if (more) begin
          ptr_nxt = ptr_r + obs_pkg::CNT_W'(1);
        end else if (kind_r == obs_pkg::KIND_REMOVE) begin
          state_nxt = obs_pkg::ST_FIND;
        end else begin
          state_nxt = obs_pkg::ST_DONE;
        end
      end
      obs_pkg::ST_FIND: begin
        if (sts_i.hit) begin
          ptr_nxt   = sts_i.hit_ptr + obs_pkg::CNT_W'(1);
          state_nxt = obs_pkg::ST_SHIFT;
        end else begin
          state_nxt = obs_pkg::ST_DONE;
        end
      end
      obs_pkg::ST_SHIFT: begin
        if (more) begin
          ptr_nxt = ptr_r + obs_pkg::CNT_W'(1);
        end else begin
          state_nxt = obs_pkg::ST_DONE;
        end
      end
      obs_pkg::ST_DONE: begin
        state_nxt = obs_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = obs_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_o        = '0;
    cmd_o.rd_ptr = ptr_r;
    busy         = 1'b1;
    out_valid    = 1'b0;
    case (state_r)
      obs_pkg::ST_IDLE: begin
        busy       = 1'b0;
        cmd_o.load = start;
        cmd_o.add  = start && (in_kind == obs_pkg::KIND_ADD) && (sts_i.cnt < lim);
      end
      obs_pkg::ST_SCAN: begin
        cmd_o.rd_en      = more;
        cmd_o.cmp_en     = 1'b1;
        cmd_o.first_only = (kind_r == obs_pkg::KIND_REMOVE);
      end
      obs_pkg::ST_FIND: begin
        cmd_o.first_only = 1'b1;
      end
      obs_pkg::ST_SHIFT: begin
        cmd_o.rd_en    = more;
        cmd_o.shift_wr = 1'b1;
        cmd_o.cnt_dec  = !more;
      end
      obs_pkg::ST_DONE: begin
        out_valid = 1'b1;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("Accepted request did not make the block busy.");

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("Result strobe lasted more than one cycle.");

  a_shift_needs_hit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == obs_pkg::ST_SHIFT) |-> sts_i.hit)
    else $error("Slot shift started without a matching block.");

  a_ptr_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == obs_pkg::ST_SCAN || state_r == obs_pkg::ST_SHIFT) |-> (ptr_r <= sts_i.cnt))
    else $error("Slot pointer ran beyond the block count.");

endmodule

`default_nettype wire

[sv/oblivious_bucket_store_core.sv]
// Top level of the oblivious bucket store: APB capacity register and the two sub-blocks.
// Instantiates obs_ctrl and obs_dp; depends on obs_pkg.
`default_nettype none

// A request is taken when start is high and busy is low; its single result appears for one
// cycle with out_valid and cannot be held off. Every lookup and remove reads each occupied
// slot in turn through the one read port of the slot memory, whatever the index, so a
// lookup's time depends only on the block count n. When the first matching block of a remove
// sits in slot h, the later slots are then shifted down one per cycle, so the time of a
// remove also depends on h.
// The memory needs no clearing after reset; the capacity register resets to four.

module oblivious_bucket_store_core #(
  parameter int SLOTS        = obs_pkg::SLOTS_DEF,
  parameter int PAYLOAD_BITS = obs_pkg::PAYLOAD_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [obs_pkg::KIND_W-1:0]        in_kind,
  input  logic signed [obs_pkg::IDX_W-1:0]  in_block_index,
  input  logic signed [obs_pkg::LEAF_W-1:0] in_leaf_id,
  input  logic [obs_pkg::PAY_W-1:0]         in_payload,
  input  logic [obs_pkg::SIZE_W-1:0]        in_payload_size,
  output logic                              out_valid,
  output logic                              out_success,
  output logic signed [obs_pkg::IDX_W-1:0]  out_found_index,
  output logic signed [obs_pkg::LEAF_W-1:0] out_found_leaf,
  output logic [obs_pkg::PAY_W-1:0]         out_found_payload,
  output logic [obs_pkg::SIZE_W-1:0]        out_found_size,
  output logic [obs_pkg::CNT_W-1:0]         out_occupancy,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [obs_pkg::APB_AW-1:0]        paddr,
  input  logic [obs_pkg::APB_DW-1:0]        pwdata,
  output logic [obs_pkg::APB_DW-1:0]        prdata,
  output logic                              pready
);

  logic [obs_pkg::CAP_W-1:0] cap_r;
  logic                      cap_sel;
  obs_pkg::cmd_t             cmd;
  obs_pkg::sts_t             sts;

  assign pready  = 1'b1;
  assign cap_sel = (paddr[obs_pkg::APB_AW-1] == obs_pkg::CFG_IDX_CAPACITY);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= obs_pkg::CAP_RESET;
    end else if (psel && penable && pwrite && pready && cap_sel) begin
      cap_r <= pwdata[obs_pkg::CAP_W-1:0];
    end
  end

  assign prdata = cap_sel ? obs_pkg::APB_DW'(cap_r) : '0;

  obs_ctrl #(
    .SLOTS(SLOTS)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .in_kind  (in_kind),
    .cap_i    (cap_r),
    .sts_i    (sts),
    .cmd_o    (cmd),
    .busy     (busy),
    .out_valid(out_valid)
  );

  obs_dp #(
    .SLOTS       (SLOTS),
    .PAYLOAD_BITS(PAYLOAD_BITS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .in_block_index   (in_block_index),
    .in_leaf_id       (in_leaf_id),
    .in_payload       (in_payload),
    .in_payload_size  (in_payload_size),
    .out_success      (out_success),
    .out_found_index  (out_found_index),
    .out_found_leaf   (out_found_leaf),
    .out_found_payload(out_found_payload),
    .out_found_size   (out_found_size),
    .out_occupancy    (out_occupancy)
  );

endmodule

`default_nettype wire
